>>> hw/rtl/chm_pkg.sv
// ----------------------------------------------------------------------------
// chm_pkg: shared types and constants of the chained hash map.
// Request and response beat layouts and default sizes.
// ----------------------------------------------------------------------------
package chm_pkg;

  localparam int DEF_BUCKETS      = 2053;
  localparam int DEF_POOL_ENTRIES = 1024;
  localparam int CountWidth       = 11;
  localparam logic [CountWidth-1:0] MaxEntriesReset = 11'd768;

  localparam logic [1:0] FUNC_LOOKUP = 2'd0;
  localparam logic [1:0] FUNC_SET    = 2'd1;
  localparam logic [1:0] FUNC_REMOVE = 2'd2;
  localparam logic [1:0] FUNC_UNUSED = 2'd3;

  typedef struct packed {
    logic [1:0]         func;
    logic signed [63:0] key;
    logic signed [63:0] write_value;
  } req_t;

  typedef struct packed {
    logic               found;
    logic signed [63:0] read_value;
    logic               ok;
  } rsp_t;

endpackage

>>> hw/rtl/chained_hash_map_int64.sv
// ----------------------------------------------------------------------------
// chained_hash_map_int64: separately chained key-value table.
// Bucket heads and the entry pool sit in synchronous memories.
// ----------------------------------------------------------------------------
//   channel  | direction | beat
//   in       | input     | func, key, write_value
//   out      | output    | found, read_value, ok
//   cfg      | input     | max_entries write
// After reset a clearing pass writes null to every bucket head and threads the
// free list; no request is taken then.
// A response follows its input beat through the key reduction, the head read, the chain
// check and the response state; each chain entry visited adds a read and compare step,
// and a set that adds an entry adds a free-list step.
// One request at a time; a pending response holds off the next input beat.
module chained_hash_map_int64
  import chm_pkg::*;
#(
  parameter int BUCKETS      = DEF_BUCKETS,
  parameter int POOL_ENTRIES = DEF_POOL_ENTRIES,
  localparam int BW = $clog2(BUCKETS),
  localparam int EW = $clog2(POOL_ENTRIES + 1)
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  req_t                  in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output rsp_t                  out_data,
  input  logic                  cfg_we,
  input  logic [CountWidth-1:0] cfg_wdata
);

  localparam int IW = $clog2(POOL_ENTRIES);
  localparam logic [EW-1:0] Nil = EW'(POOL_ENTRIES);

  typedef enum logic [3:0] {
    S_CLR, S_IDLE, S_HASH, S_HEAD, S_CHK, S_READ, S_CMP, S_FREE, S_DONE
  } state_t;

  state_t state;
  logic [BW:0]   clr_b;
  logic [EW-1:0] clr_e;

  logic [EW-1:0]   head_mem [BUCKETS];
  logic [63:0]     key_mem  [POOL_ENTRIES];
  logic [63:0]     val_mem  [POOL_ENTRIES];
  logic [EW-1:0]   link_mem [POOL_ENTRIES];

  logic [EW-1:0]   head_rd, link_rd;
  logic [63:0]     key_rd, val_rd;

  req_t            req;
  logic [CountWidth-1:0] max_entries, entry_count;
  logic [EW-1:0]   free_head, cur, prev;
  logic [EW:0]     steps;
  logic            hash_start, hash_done;
  logic [BW-1:0]   bucket;
  logic            table_full;

  chm_bucket_mod #(.BUCKETS(BUCKETS)) u_mod (
    .clk(clk), .rst(rst), .start(hash_start), .key(req.key),
    .done(hash_done), .bucket(bucket)
  );

  assign in_ready = (state == S_IDLE) && !out_valid;
  assign table_full = entry_count >= max_entries || 32'(entry_count) >= POOL_ENTRIES
                      || free_head >= Nil;

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_CLR;
      clr_b       <= '0;
      clr_e       <= '0;
      out_valid   <= 1'b0;
      hash_start  <= 1'b0;
      max_entries <= MaxEntriesReset;
      entry_count <= '0;
      free_head   <= '0;
    end else begin
      hash_start <= in_valid && in_ready;
      if (cfg_we) begin
        max_entries <= cfg_wdata;
      end
      if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_CLR: begin
          if (32'(clr_b) < BUCKETS) begin
            head_mem[clr_b[BW-1:0]] <= Nil;
            clr_b <= clr_b + 1'b1;
          end
          if (clr_e < Nil) begin
            link_mem[clr_e[IW-1:0]] <= clr_e + 1'b1;
            clr_e <= clr_e + 1'b1;
          end
          if (32'(clr_b) >= BUCKETS && clr_e >= Nil) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (in_valid && in_ready) begin
            req        <= in_data;
            state      <= S_HASH;
          end
        end
        S_HASH: begin
          if (hash_done) begin
            head_rd <= head_mem[bucket];
            state   <= S_HEAD;
          end
        end
        S_HEAD: begin
          cur   <= head_rd;
          prev  <= Nil;
          steps <= '0;
          state <= S_CHK;
        end
        S_CHK: begin
          if (cur < Nil && 32'(steps) < POOL_ENTRIES) begin
            key_rd  <= key_mem[cur[IW-1:0]];
            val_rd  <= val_mem[cur[IW-1:0]];
            link_rd <= link_mem[cur[IW-1:0]];
            state   <= S_CMP;
          end else begin
            out_data.found      <= 1'b0;
            out_data.read_value <= '0;
            out_data.ok         <= !(req.func == FUNC_SET && table_full);
            if (req.func == FUNC_SET && !table_full) begin
              link_rd <= link_mem[free_head[IW-1:0]];
              state   <= S_FREE;
            end else begin
              state <= S_DONE;
            end
          end
        end
        S_FREE: begin
          free_head <= link_rd;
          key_mem[free_head[IW-1:0]]  <= req.key;
          val_mem[free_head[IW-1:0]]  <= req.write_value;
          link_mem[free_head[IW-1:0]] <= head_rd;
          head_mem[bucket]            <= free_head;
          entry_count <= entry_count + 1'b1;
          state <= S_DONE;
        end
        S_CMP: begin
          if (key_rd == req.key) begin
            out_data.found      <= (req.func != FUNC_UNUSED);
            out_data.ok         <= 1'b1;
            out_data.read_value <= (req.func == FUNC_LOOKUP) ? val_rd : '0;
            if (req.func == FUNC_SET) begin
              val_mem[cur[IW-1:0]] <= req.write_value;
            end else if (req.func == FUNC_REMOVE) begin
              if (prev < Nil) begin
                link_mem[prev[IW-1:0]] <= link_rd;
              end else begin
                head_mem[bucket] <= link_rd;
              end
              if (entry_count != '0) begin
                entry_count <= entry_count - 1'b1;
              end
            end
            state <= S_DONE;
          end else begin
            prev  <= cur;
            cur   <= link_rd;
            steps <= steps + 1'b1;
            state <= S_CHK;
          end
        end
        S_DONE: begin
          if (req.func == FUNC_REMOVE && out_data.found) begin
            link_mem[cur[IW-1:0]] <= free_head;
            free_head             <= cur;
          end
          out_valid <= 1'b1;
          state     <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

>>> hw/rtl/chm_bucket_mod.sv
// ----------------------------------------------------------------------------
// chm_bucket_mod: key modulo bucket count.
// Reduces the 64-bit unsigned key 16 bits at a time, most significant first,
// by reciprocal multiplication; each digit takes a quotient step and a remainder step.
// ----------------------------------------------------------------------------
module chm_bucket_mod
  import chm_pkg::*;
#(
  parameter int BUCKETS = DEF_BUCKETS,
  localparam int BW = $clog2(BUCKETS)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  logic [63:0]   key,
  output logic          done,
  output logic [BW-1:0] bucket
);

  localparam int YW = BW + 16;
  localparam int K  = YW + BW;
  localparam logic [63:0] Recip64 =
    ((64'd1 << K) + 64'(BUCKETS) - 64'd1) / 64'(BUCKETS);
  localparam logic [YW:0] Recip = Recip64[YW:0];
  localparam logic [BW:0] Mod = (BW+1)'(BUCKETS);

  logic [63:0]   shreg;
  logic [YW-1:0] y;
  logic [15:0]   q;
  logic [1:0]    cnt;
  logic          busy;
  logic          phase;
  logic [2*YW:0] prod;
  logic [YW-1:0] qb;
  logic [YW-1:0] rem;

  assign prod = (2*YW+1)'(y) * (2*YW+1)'(Recip);
  assign qb   = YW'(q) * YW'(Mod);
  assign rem  = y - qb;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= busy && phase && (cnt == 2'd0);
      if (start) begin
        busy  <= 1'b1;
        phase <= 1'b0;
        cnt   <= 2'd3;
        y     <= YW'(key[63:48]);
        shreg <= {key[47:0], 16'h0000};
      end else if (busy && !phase) begin
        q     <= prod[K +: 16];
        phase <= 1'b1;
      end else if (busy) begin
        phase <= 1'b0;
        if (cnt == 2'd0) begin
          busy   <= 1'b0;
          bucket <= rem[BW-1:0];
        end else begin
          y     <= {rem[BW-1:0], shreg[63:48]};
          shreg <= {shreg[47:0], 16'h0000};
          cnt   <= cnt - 2'd1;
        end
      end
    end
  end

endmodule

>>> test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the chained hash map.
// Lookups, sets, removes and unused codes go in, directed and at random,
// with random gaps on both sides. A software copy of the table predicts
// each response; a scoreboard compares every beat with the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top
  import chm_pkg::*;
();

  localparam int NBUCK = 2053;
  localparam int NPOOL = 1024;
  localparam int NIL = NPOOL;
  localparam int IDLE_LIMIT = 20000;

  class rsp_scoreboard;
    rsp_t pending[$];
    int errors;

    function void note_request(rsp_t r);
      pending.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected response %p", got);
        return;
      end
      want = pending.pop_front();
      if (got.found !== want.found || got.read_value !== want.read_value ||
          got.ok !== want.ok) begin
        errors++;
        if (errors <= 10) $display("expected %p got %p", want, got);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  req_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  rsp_t out_data;
  logic cfg_we = 0;
  logic [CountWidth-1:0] cfg_wdata = '0;

  always begin
    #1 clk = 1;
    #1 clk = 0;
  end

  chained_hash_map_int64 dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  rsp_scoreboard sb = new();

  int unsigned limit_m;
  int unsigned heads[NBUCK];
  logic [63:0] tkey[NPOOL];
  logic [63:0] tval[NPOOL];
  int unsigned tlink[NPOOL];
  int unsigned free_ptr;
  int unsigned used;
  logic [63:0] key_pool[$];
  int idle_cycles = 0;
  int unsigned rx_gap = 0;
  bit hold_off = 0;

  function automatic rsp_t table_apply(req_t q);
    rsp_t r;
    logic [63:0] k;
    int unsigned b, cur, prv, hit, steps, e;
    k = q.key;
    b = 32'(k % 64'(NBUCK));
    r.found = 0; r.read_value = '0; r.ok = 1;
    cur = heads[b]; prv = NIL; hit = NIL; steps = 0;
    while (cur < NPOOL && steps < NPOOL) begin
      if (tkey[cur] == k) begin
        hit = cur;
        break;
      end
      prv = cur; cur = tlink[cur]; steps++;
    end
    if (q.func == FUNC_LOOKUP) begin
      if (hit < NPOOL) begin
        r.found = 1; r.read_value = tval[hit];
      end
    end else if (q.func == FUNC_SET) begin
      if (hit < NPOOL) begin
        r.found = 1; tval[hit] = q.write_value;
      end else if (used >= limit_m || used >= NPOOL || free_ptr >= NPOOL) begin
        r.ok = 0;
      end else begin
        e = free_ptr; free_ptr = tlink[e];
        tkey[e] = k; tval[e] = q.write_value;
        tlink[e] = heads[b]; heads[b] = e; used++;
      end
    end else if (q.func == FUNC_REMOVE) begin
      if (hit < NPOOL) begin
        r.found = 1;
        if (prv < NPOOL) tlink[prv] = tlink[hit];
        else heads[b] = tlink[hit];
        tlink[hit] = free_ptr; free_ptr = hit;
        if (used > 0) used--;
      end
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 40) return 0;
    if (p < 90) return $urandom_range(1, 4);
    if (p < 98) return $urandom_range(5, 30);
    return $urandom_range(100, 400);
  endfunction

  function automatic logic [63:0] rand64();
    return {$urandom, $urandom};
  endfunction

  function automatic logic [63:0] pick_key();
    int unsigned p;
    logic [63:0] k;
    p = $urandom_range(0, 99);
    if (key_pool.size() > 0 && p < 65) return key_pool[$urandom_range(0, key_pool.size() - 1)];
    if (p < 80) begin
      k = rand64();
      key_pool.push_back(k);
      if (key_pool.size() > 300) void'(key_pool.pop_front());
      return k;
    end
    if (p < 92) begin
      k = 64'(NBUCK * $urandom_range(0, 20) + $urandom_range(0, 2));
      key_pool.push_back(k);
      return k;
    end
    return rand64();
  endfunction

  task automatic send(logic [1:0] f, logic [63:0] k, logic [63:0] v);
    req_t q;
    q.func = f; q.key = k; q.write_value = v;
    in_valid <= 1;
    in_data <= q;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    sb.note_request(table_apply(q));
  endtask

  task automatic send_gap(logic [1:0] f, logic [63:0] k, logic [63:0] v);
    int unsigned g;
    send(f, k, v);
    g = gap_len();
    if (g != 0) begin
      in_valid <= 0;
      repeat (g) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (200) @(posedge clk);
  endtask

  task automatic set_limit(int unsigned m);
    cfg_we <= 1;
    cfg_wdata <= m[CountWidth-1:0];
    @(posedge clk);
    cfg_we <= 0;
    limit_m = m & 11'h7FF;
  endtask

  task automatic random_phase(int n, int set_bias);
    int unsigned p;
    logic [1:0] f;
    for (int i = 0; i < n; i++) begin
      p = $urandom_range(0, 99);
      if (p < set_bias) f = FUNC_SET;
      else if (p < set_bias + (100 - set_bias) / 2) f = FUNC_LOOKUP;
      else if (p < 98) f = FUNC_REMOVE;
      else f = FUNC_UNUSED;
      send_gap(f, pick_key(), rand64());
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 0;
    end else if (hold_off) begin
      out_ready <= 0;
    end else if (out_valid && out_ready) begin
      sb.check_response(out_data);
      rx_gap = gap_len();
      out_ready <= (rx_gap == 0);
    end else if (!out_ready) begin
      if (rx_gap == 0) out_ready <= 1;
      else rx_gap = rx_gap - 1;
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || rst) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    for (int i = 0; i < NBUCK; i++) heads[i] = NIL;
    for (int i = 0; i < NPOOL; i++) begin
      tkey[i] = '0; tval[i] = '0; tlink[i] = i + 1;
    end
    free_ptr = 0; used = 0; limit_m = MaxEntriesReset;
    repeat (10) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    send(FUNC_LOOKUP, 64'h8000_0000_0000_0000, '0);
    send(FUNC_SET, 64'h8000_0000_0000_0000, 64'h7FFF_FFFF_FFFF_FFFF);
    send(FUNC_SET, 64'h7FFF_FFFF_FFFF_FFFF, 64'h8000_0000_0000_0000);
    send(FUNC_SET, '1, '1);
    send(FUNC_SET, 64'd0, 64'd0);
    send(FUNC_SET, 64'(NBUCK), 64'd11);
    send(FUNC_SET, 64'(2 * NBUCK), 64'd22);
    send(FUNC_LOOKUP, 64'(NBUCK), '0);
    send(FUNC_LOOKUP, 64'd0, '0);
    send(FUNC_SET, 64'(NBUCK), 64'd33);
    send(FUNC_REMOVE, 64'(NBUCK), '0);
    send(FUNC_LOOKUP, 64'(NBUCK), '0);
    send(FUNC_REMOVE, 64'(NBUCK), '0);
    send(FUNC_LOOKUP, 64'(2 * NBUCK), '0);
    send(FUNC_REMOVE, 64'(2 * NBUCK), '0);
    send(FUNC_LOOKUP, '1, '0);
    send(FUNC_UNUSED, 64'd0, 64'd5);
    send(FUNC_LOOKUP, 64'h8000_0000_0000_0000, '0);
    drain();

    set_limit(0);
    send(FUNC_SET, 64'd12345, 64'd1);
    send(FUNC_SET, 64'd0, 64'd9);
    send(FUNC_LOOKUP, 64'd12345, '0);
    drain();

    set_limit(1);
    random_phase(150, 40);
    drain();

    set_limit(2047);
    fork
      begin
        hold_off <= 1;
        repeat (2000) @(posedge clk);
        hold_off <= 0;
      end
      random_phase(600, 80);
    join
    drain();

    set_limit($urandom_range(3, 40));
    random_phase(300, 50);
    drain();

    set_limit(1024);
    random_phase(480, 40);
    drain();

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
